@@ design/hard_sphere_metropolis_move_macros.svh @@
// Assertion macros for the hard-sphere Metropolis move engine.
// No dependencies; include with the bare file name.
`ifndef HARD_SPHERE_METROPOLIS_MOVE_MACROS_SVH
`define HARD_SPHERE_METROPOLIS_MOVE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hsm_pkg.sv @@
// Shared types and constants for the hard-sphere Metropolis move engine.
// No dependencies.
package hsm_pkg;

    localparam int MAX_SPHERES = 1024;
    localparam int COORD_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_SPHERES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int RAD_W       = COORD_BITS - 1;
    localparam int POS_W       = COORD_BITS + 2;   // signed trial position
    localparam int PROD_W      = 2 * COORD_BITS + 2;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_TRIAL = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_REDRAW = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [RAD_W-1:0]      r;
    } t_sphere;

    localparam int SPHERE_W = $bits(t_sphere);

    // Control word from the sequencer to the overlap pipeline.
    typedef struct packed {
        logic clear;   // restart the sticky hit flag
        logic valid;   // other sphere on the data input is to be tested
    } t_ovl_ctrl;

endpackage

@@ design/hsm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hsm_ram #(
    parameter int DW = 8,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [(1 << AW)];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/hsm_disp.sv @@
// Shared displacement unit: registered product radius*(2u-one), then rounding add.
// Depends on hsm_pkg.
module hsm_disp
    import hsm_pkg::*;
(
    input  logic                    i_clk,
    input  logic [COORD_BITS-1:0]   i_coord,
    input  logic [RAD_W-1:0]        i_radius,
    input  logic [COORD_BITS-1:0]   i_rand,
    output logic signed [POS_W-1:0] o_pos
);

    localparam logic signed [POS_W-1:0]  ONE_S  = POS_W'(1) <<< COORD_BITS;
    localparam logic signed [PROD_W-1:0] HALF_S = PROD_W'(1) <<< (COORD_BITS - 1);

    logic signed [POS_W-1:0]  w_twou;
    logic signed [COORD_BITS:0] w_rad_s;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_round;
    logic signed [POS_W-1:0]  w_delta;

    assign w_twou  = $signed({1'b0, i_rand, 1'b0}) - ONE_S;
    assign w_rad_s = $signed({2'b00, i_radius});

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_rad_s) * PROD_W'(w_twou);
    end

    // floor((p + one/2) / one): take the upper bits of the rounded product
    assign w_round = r_prod + HALF_S;
    assign w_delta = $signed(w_round[PROD_W-1:COORD_BITS]);
    assign o_pos   = $signed({2'b00, i_coord}) + w_delta;

endmodule

@@ design/hsm_ovl.sv @@
// Overlap test pipeline: abs differences, squares, then sum and compare.
// Depends on hsm_pkg.
module hsm_ovl
    import hsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ovl_ctrl             i_ctrl,
    input  t_sphere               i_other,
    input  logic [COORD_BITS-1:0] i_tx,
    input  logic [COORD_BITS-1:0] i_ty,
    input  logic [COORD_BITS-1:0] i_tz,
    input  logic [RAD_W-1:0]      i_radius,
    output logic                  o_hit
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 2;

    logic [COORD_BITS:0]   w_dx, w_dy, w_dz;
    logic [COORD_BITS-1:0] r_ax, r_ay, r_az, r_s;
    logic [SQ_W-1:0]       r_sqx, r_sqy, r_sqz, r_s2;
    logic                  r_va, r_vb, r_hit;
    logic [SUM_W-1:0]      w_d2;

    assign w_dx = {1'b0, i_tx} - {1'b0, i_other.x};
    assign w_dy = {1'b0, i_ty} - {1'b0, i_other.y};
    assign w_dz = {1'b0, i_tz} - {1'b0, i_other.z};

    always_ff @(posedge i_clk) begin
        r_ax  <= w_dx[COORD_BITS] ? COORD_BITS'(-w_dx) : w_dx[COORD_BITS-1:0];
        r_ay  <= w_dy[COORD_BITS] ? COORD_BITS'(-w_dy) : w_dy[COORD_BITS-1:0];
        r_az  <= w_dz[COORD_BITS] ? COORD_BITS'(-w_dz) : w_dz[COORD_BITS-1:0];
        r_s   <= COORD_BITS'({1'b0, i_radius}) + COORD_BITS'({1'b0, i_other.r});
        r_sqx <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sqy <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_sqz <= SQ_W'(r_az) * SQ_W'(r_az);
        r_s2  <= SQ_W'(r_s) * SQ_W'(r_s);
    end

    assign w_d2 = SUM_W'(r_sqx) + SUM_W'(r_sqy) + SUM_W'(r_sqz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_va <= i_ctrl.valid;
            r_vb <= r_va;
            if (i_ctrl.clear) begin
                r_hit <= 1'b0;
            end else if (r_vb && (w_d2 < SUM_W'(r_s2))) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_hit = r_hit;

endmodule

@@ design/hard_sphere_metropolis_move.sv @@
// Hard-sphere Metropolis move engine. Loads and ignored items leave busy low, a read
// passes through S_RDO, and a trial's time grows with n (n = spheres in use, up to 1024).
// The trial time is set by the overlap scan: one sphere-store read a cycle.
// One result word a cycle-wide strobe; the receiver cannot stall. Reset (synchronous,
// active low) clears the sequencer, counters and strobe, sets the count to 1024 and
// leaves the sphere store undefined until loaded.
module hard_sphere_metropolis_move
    import hsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CNT_W-1:0]      i_cfg_wdata,
    input  logic [1:0]            i_req_type,
    input  logic [IDX_W-1:0]      i_particle_index,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [COORD_BITS-1:0] i_pos_z,
    input  logic [RAD_W-1:0]      i_sphere_radius,
    input  logic [COORD_BITS-1:0] i_rand_x,
    input  logic [COORD_BITS-1:0] i_rand_y,
    input  logic [COORD_BITS-1:0] i_rand_z,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [IDX_W-1:0]      o_moved_index,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic [COORD_BITS-1:0] o_out_z,
    output logic [RAD_W-1:0]      o_out_radius,
    output logic [31:0]           o_accepted_count
);

    `include "hard_sphere_metropolis_move_macros.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDO   = 4'd1;   // read item: store data arrives
    localparam logic [3:0] S_MOD   = 4'd2;   // current sphere mod count, bit a cycle
    localparam logic [3:0] S_RDI   = 4'd3;   // fetch the sphere under trial
    localparam logic [3:0] S_LATCH = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;   // displacement product, one axis
    localparam logic [3:0] S_ADD   = 4'd6;   // rounding add, one axis
    localparam logic [3:0] S_CHK   = 4'd7;   // box test
    localparam logic [3:0] S_SCAN  = 4'd8;   // one other sphere a cycle
    localparam logic [3:0] S_DRAIN = 4'd9;   // flush the overlap pipeline
    localparam logic [3:0] S_FIN   = 4'd10;

    localparam int MODB_W = $clog2(IDX_W);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SPHERES);
    localparam logic signed [POS_W-1:0] ONE_S = POS_W'(1) <<< COORD_BITS;

    logic [3:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      w_n_use;
    logic [IDX_W-1:0]      r_cur;
    logic [31:0]           r_acc;
    logic [IDX_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_mod_rem, n_mod_rem;
    logic [CNT_W-1:0]      w_rem_sh;
    logic [MODB_W-1:0]     r_mod_bit;
    t_sphere               r_self;
    logic [COORD_BITS-1:0] r_rx, r_ry, r_rz;
    logic signed [POS_W-1:0] r_vx, r_vy, r_vz;
    logic [1:0]            r_axis;
    logic [IDX_W-1:0]      r_k;
    logic [1:0]            r_drain;
    logic                  r_tag_v, r_tag_skip;

    logic                  w_accept;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr, w_raddr;
    t_sphere               w_wdata, w_rdata;
    logic [COORD_BITS-1:0] w_coord_sel, w_rand_sel;
    logic signed [POS_W-1:0] w_pos;
    logic                  w_inside;
    logic                  w_hit;
    t_ovl_ctrl             w_ovl_ctrl;
    logic                  w_scan_last;
    logic [IDX_W-1:0]      w_next_cur;

    logic                  r_o_valid;
    logic [1:0]            r_o_status;
    logic [IDX_W-1:0]      r_o_idx;
    t_sphere               r_o_sph;
    logic [31:0]           r_o_acc;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // Clamp the count in use to one..MAX_SPHERES
    assign w_n_use = (r_count == '0) ? CNT_W'(1) :
                     (r_count > MAX_CNT) ? MAX_CNT : r_count;

    // Restoring remainder step: shift in the next bit of the current sphere
    assign w_rem_sh  = {r_mod_rem[CNT_W-2:0], r_cur[r_mod_bit]};
    assign n_mod_rem = (w_rem_sh >= w_n_use) ? (w_rem_sh - w_n_use) : w_rem_sh;

    // Sphere store
    assign w_we    = (w_accept && (i_req_type == REQ_LOAD)) || ((r_state == S_FIN) && !w_hit);
    assign w_waddr = (r_state == S_FIN) ? r_idx : i_particle_index;
    assign w_wdata = (r_state == S_FIN) ?
                     t_sphere'{x: r_vx[COORD_BITS-1:0], y: r_vy[COORD_BITS-1:0],
                               z: r_vz[COORD_BITS-1:0], r: r_self.r} :
                     t_sphere'{x: i_pos_x, y: i_pos_y, z: i_pos_z, r: i_sphere_radius};

    always_comb begin
        unique case (r_state)
            S_SCAN:  w_raddr = r_k;
            S_RDI:   w_raddr = r_idx;
            default: w_raddr = i_particle_index;
        endcase
    end

    hsm_ram #(
        .DW (SPHERE_W),
        .AW (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Displacement unit, shared over the three axes
    always_comb begin
        case (r_axis)
            2'd0:    begin w_coord_sel = r_self.x; w_rand_sel = r_rx; end
            2'd1:    begin w_coord_sel = r_self.y; w_rand_sel = r_ry; end
            default: begin w_coord_sel = r_self.z; w_rand_sel = r_rz; end
        endcase
    end

    hsm_disp u_disp (
        .i_clk    (i_clk),
        .i_coord  (w_coord_sel),
        .i_radius (r_self.r),
        .i_rand   (w_rand_sel),
        .o_pos    (w_pos)
    );

    // Strictly inside on every axis: equality at an edge is outside
    function automatic logic axis_in(input logic signed [POS_W-1:0] v,
                                     input logic [RAD_W-1:0] r);
        logic signed [POS_W-1:0] rs;
        rs = $signed(POS_W'(r));
        return (v > rs) && (v < (ONE_S - rs));
    endfunction

    assign w_inside = axis_in(r_vx, r_self.r) && axis_in(r_vy, r_self.r) &&
                      axis_in(r_vz, r_self.r);

    // Overlap pipeline; the word under test skips the sphere being moved
    assign w_ovl_ctrl.clear = (r_state == S_CHK);
    assign w_ovl_ctrl.valid = r_tag_v && !r_tag_skip;

    hsm_ovl u_ovl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ovl_ctrl),
        .i_other  (w_rdata),
        .i_tx     (r_vx[COORD_BITS-1:0]),
        .i_ty     (r_vy[COORD_BITS-1:0]),
        .i_tz     (r_vz[COORD_BITS-1:0]),
        .i_radius (r_self.r),
        .o_hit    (w_hit)
    );

    assign w_scan_last = ({1'b0, r_k} == (w_n_use - CNT_W'(1)));
    assign w_next_cur  = (({1'b0, r_idx} + CNT_W'(1)) >= w_n_use) ? '0 : (r_idx + IDX_W'(1));

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req_type == REQ_TRIAL)) begin
                    n_state = S_MOD;
                end else if (w_accept && (i_req_type == REQ_READ)) begin
                    n_state = S_RDO;
                end
            end
            S_RDO:   n_state = S_IDLE;
            S_MOD:   n_state = (r_mod_bit == '0) ? S_RDI : S_MOD;
            S_RDI:   n_state = S_LATCH;
            S_LATCH: n_state = S_MUL;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = (r_axis == 2'd2) ? S_CHK : S_MUL;
            S_CHK:   n_state = w_inside ? S_SCAN : S_IDLE;
            S_SCAN:  n_state = w_scan_last ? S_DRAIN : S_SCAN;
            S_DRAIN: n_state = (r_drain == 2'd2) ? S_FIN : S_DRAIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= MAX_CNT;
            r_cur     <= '0;
            r_acc     <= '0;
            r_tag_v   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tag_v   <= (r_state == S_SCAN);
            r_o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (w_accept && (i_req_type == REQ_LOAD)) begin
                // a load restarts the walk and the accept tally
                r_cur     <= '0;
                r_acc     <= '0;
                r_o_valid <= 1'b1;
            end
            if (r_state == S_RDO) begin
                r_o_valid <= 1'b1;
            end
            if ((r_state == S_CHK) && !w_inside) begin
                r_o_valid <= 1'b1;   // redraw: nothing changes
            end
            if (r_state == S_FIN) begin
                r_cur     <= w_next_cur;
                r_o_valid <= 1'b1;
                if (!w_hit) begin
                    r_acc <= r_acc + 32'd1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_tag_skip <= (r_k == r_idx);
        unique case (r_state)
            S_IDLE: begin
                r_idx     <= i_particle_index;
                r_rx      <= i_rand_x;
                r_ry      <= i_rand_y;
                r_rz      <= i_rand_z;
                r_mod_rem <= '0;
                r_mod_bit <= MODB_W'(IDX_W - 1);
                r_axis    <= 2'd0;
                r_k       <= '0;
                r_drain   <= 2'd0;
            end
            S_MOD: begin
                r_mod_rem <= n_mod_rem;
                r_mod_bit <= r_mod_bit - MODB_W'(1);
                if (r_mod_bit == '0) begin
                    r_idx <= n_mod_rem[IDX_W-1:0];
                end
            end
            S_LATCH: r_self <= w_rdata;
            S_ADD: begin
                case (r_axis)
                    2'd0:    r_vx <= w_pos;
                    2'd1:    r_vy <= w_pos;
                    default: r_vz <= w_pos;
                endcase
                r_axis <= r_axis + 2'd1;
            end
            S_SCAN:  r_k <= r_k + IDX_W'(1);
            S_DRAIN: r_drain <= r_drain + 2'd1;
            default: ;
        endcase
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req_type == REQ_LOAD)) begin
            r_o_status <= ST_DONE;
            r_o_idx    <= i_particle_index;
            r_o_sph    <= t_sphere'{x: i_pos_x, y: i_pos_y, z: i_pos_z, r: i_sphere_radius};
            r_o_acc    <= '0;
        end else if (r_state == S_RDO) begin
            r_o_status <= ST_DONE;
            r_o_idx    <= r_idx;
            r_o_sph    <= w_rdata;
            r_o_acc    <= r_acc;
        end else if ((r_state == S_CHK) && !w_inside) begin
            r_o_status <= ST_REDRAW;
            r_o_idx    <= r_idx;
            r_o_sph    <= r_self;
            r_o_acc    <= r_acc;
        end else if (r_state == S_FIN) begin
            r_o_idx <= r_idx;
            if (w_hit) begin
                r_o_status <= ST_REJECT;
                r_o_sph    <= r_self;
                r_o_acc    <= r_acc;
            end else begin
                r_o_status <= ST_ACCEPT;
                r_o_sph    <= w_wdata;
                r_o_acc    <= r_acc + 32'd1;
            end
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_moved_index    = r_o_idx;
    assign o_out_x          = r_o_sph.x;
    assign o_out_y          = r_o_sph.y;
    assign o_out_z          = r_o_sph.z;
    assign o_out_radius     = r_o_sph.r;
    assign o_accepted_count = r_o_acc;

    // A trial result is only given once the sequencer is back at rest
    `HSM_ASSERT_NOW(a_trial_done_idle, i_clk, i_rst_n, o_valid && (o_status != ST_DONE), !busy, "trial result while busy")
    // The reduced sphere index always lies below the count in use
    `HSM_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, r_state == S_RDI, {1'b0, r_idx} < w_n_use, "trial index not below count")
    // The scan never addresses a sphere beyond the count in use
    `HSM_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN, {1'b0, r_k} < w_n_use, "scan index beyond count")
    // The scan only ends into the pipeline flush
    `HSM_ASSERT_NEXT(a_scan_to_drain, i_clk, i_rst_n, r_state == S_SCAN, (r_state == S_SCAN) || (r_state == S_DRAIN), "scan left without drain")

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for hard_sphere_metropolis_move: loads, reads and trial moves,
// with every result word checked against a predictor held in a scoreboard class.
// Depends on hsm_pkg and the hard_sphere_metropolis_move RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hsm_pkg::*;

    // Request code the block ignores; it returns no word for it.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int LIMIT_CYCLES  = 10_000_000;  // several times the slowest legal run
    localparam int SETTLE_CYCLES = 4;           // loads and ignored words never raise busy
    localparam int TAIL_CYCLES   = 40;          // catch stray words once all have arrived
    localparam int RANDOM_WORDS  = 570;
    localparam int REPORT_LIMIT  = 10;

    // One input word, fields in port order.
    typedef struct packed {
        logic [1:0]            req;
        logic [IDX_W-1:0]      idx;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [COORD_BITS-1:0] pz;
        logic [RAD_W-1:0]      rad;
        logic [COORD_BITS-1:0] ux;
        logic [COORD_BITS-1:0] uy;
        logic [COORD_BITS-1:0] uz;
    } sphere_req_t;

    // One result word, fields in port order.
    typedef struct packed {
        logic [1:0]            status;
        logic [IDX_W-1:0]      idx;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [RAD_W-1:0]      rad;
        logic [31:0]           accepted;
    } sphere_word_t;

    // Holds its own copy of the sphere store, the move counters and the count register,
    // works out the word each accepted request must produce and checks words in order.
    class move_scoreboard;
        logic [COORD_BITS-1:0] x_pos  [MAX_SPHERES];
        logic [COORD_BITS-1:0] y_pos  [MAX_SPHERES];
        logic [COORD_BITS-1:0] z_pos  [MAX_SPHERES];
        logic [RAD_W-1:0]      radius [MAX_SPHERES];
        logic [IDX_W-1:0]      next_sphere;
        logic [31:0]           accept_total;
        logic [CNT_W-1:0]      count_reg;
        sphere_word_t          awaited_q[$];
        int                    mismatches;
        int                    words_checked;
        int                    status_seen[4];

        function new();
            foreach (x_pos[k]) begin
                x_pos[k]  = '0;
                y_pos[k]  = '0;
                z_pos[k]  = '0;
                radius[k] = '0;
            end
            next_sphere   = '0;
            accept_total  = '0;
            count_reg     = CNT_W'(MAX_SPHERES);
            mismatches    = 0;
            words_checked = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        // Zero counts as one sphere, anything past the store as the full store.
        function int in_use();
            if (count_reg == 0) return 1;
            if (count_reg > MAX_SPHERES) return MAX_SPHERES;
            return int'(count_reg);
        endfunction

        function void set_count(logic [CNT_W-1:0] value);
            count_reg = value;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // c + r*(2u-1) on one axis, rounded to nearest with ties upward; kept wide and signed.
        function longint trial_axis(logic [COORD_BITS-1:0] c, logic [RAD_W-1:0] r,
                                    logic [COORD_BITS-1:0] u);
            longint one;
            longint prod;
            one  = longint'(1) << COORD_BITS;
            prod = longint'(r) * (2 * longint'(u) - one);
            return longint'(c) + ((prod + one / 2) >>> COORD_BITS);
        endfunction

        // Strictly inside the box: touching a wall counts as outside.
        function bit in_box(longint v, logic [RAD_W-1:0] r);
            return v > longint'(r) && v < (longint'(1) << COORD_BITS) - longint'(r);
        endfunction

        function void note_word(sphere_req_t w);
            sphere_word_t res;
            int           n;
            int           i;
            int           k;
            longint       nx, ny, nz, dx, dy, dz, reach;
            bit           hit;
            res = '0;
            case (w.req)
                REQ_LOAD: begin
                    next_sphere  = '0;
                    accept_total = '0;
                    x_pos[w.idx]  = w.px;
                    y_pos[w.idx]  = w.py;
                    z_pos[w.idx]  = w.pz;
                    radius[w.idx] = w.rad;
                    res.status = ST_DONE;
                    res.idx    = w.idx;
                end
                REQ_READ: begin
                    res.status = ST_DONE;
                    res.idx    = w.idx;
                end
                REQ_TRIAL: begin
                    n  = in_use();
                    i  = int'(next_sphere) % n;
                    nx = trial_axis(x_pos[i], radius[i], w.ux);
                    ny = trial_axis(y_pos[i], radius[i], w.uy);
                    nz = trial_axis(z_pos[i], radius[i], w.uz);
                    if (!(in_box(nx, radius[i]) && in_box(ny, radius[i]) &&
                          in_box(nz, radius[i]))) begin
                        // Redraw: nothing moves, the turn does not pass on.
                        res.status = ST_REDRAW;
                    end else begin
                        hit = 1'b0;
                        for (k = 0; k < n && !hit; k++) begin
                            if (k != i) begin
                                dx    = nx - longint'(x_pos[k]);
                                dy    = ny - longint'(y_pos[k]);
                                dz    = nz - longint'(z_pos[k]);
                                reach = longint'(radius[i]) + longint'(radius[k]);
                                hit   = (dx * dx + dy * dy + dz * dz) < reach * reach;
                            end
                        end
                        if (!hit) begin
                            x_pos[i]     = nx[COORD_BITS-1:0];
                            y_pos[i]     = ny[COORD_BITS-1:0];
                            z_pos[i]     = nz[COORD_BITS-1:0];
                            accept_total = accept_total + 32'd1;
                        end
                        next_sphere = (i + 1 >= n) ? '0 : IDX_W'(i + 1);
                        res.status  = hit ? ST_REJECT : ST_ACCEPT;
                    end
                    res.idx = IDX_W'(i);
                end
                default: return;
            endcase
            res.x        = x_pos[res.idx];
            res.y        = y_pos[res.idx];
            res.z        = z_pos[res.idx];
            res.rad      = radius[res.idx];
            res.accepted = accept_total;
            awaited_q.push_back(res);
        endfunction

        function void check_word(sphere_word_t got);
            sphere_word_t want;
            string        bad;
            words_checked++;
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR %0t: word with nothing awaited: st %0d idx %0d acc %0d",
                             $time, got.status, got.idx, got.accepted);
                return;
            end
            want = awaited_q.pop_front();
            status_seen[want.status]++;
            bad = "";
            if (got.status   !== want.status)   bad = {bad, " status"};
            if (got.idx      !== want.idx)      bad = {bad, " moved_index"};
            if (got.x        !== want.x)        bad = {bad, " out_x"};
            if (got.y        !== want.y)        bad = {bad, " out_y"};
            if (got.z        !== want.z)        bad = {bad, " out_z"};
            if (got.rad      !== want.rad)      bad = {bad, " out_radius"};
            if (got.accepted !== want.accepted) bad = {bad, " accepted_count"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"ERROR %0t: mismatch in%s\n",
                              "  expected st %0d idx %0d x %h y %h z %h r %h acc %0d\n",
                              "  actual   st %0d idx %0d x %h y %h z %h r %h acc %0d"},
                             $time, bad,
                             want.status, want.idx, want.x, want.y, want.z, want.rad,
                             want.accepted,
                             got.status, got.idx, got.x, got.y, got.z, got.rad,
                             got.accepted);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n          = 1'b0;
    logic                  start            = 1'b0;
    logic                  busy;
    logic                  i_cfg_we         = 1'b0;
    logic [CNT_W-1:0]      i_cfg_wdata      = '0;
    logic [1:0]            i_req_type       = '0;
    logic [IDX_W-1:0]      i_particle_index = '0;
    logic [COORD_BITS-1:0] i_pos_x          = '0;
    logic [COORD_BITS-1:0] i_pos_y          = '0;
    logic [COORD_BITS-1:0] i_pos_z          = '0;
    logic [RAD_W-1:0]      i_sphere_radius  = '0;
    logic [COORD_BITS-1:0] i_rand_x         = '0;
    logic [COORD_BITS-1:0] i_rand_y         = '0;
    logic [COORD_BITS-1:0] i_rand_z         = '0;
    logic                  o_valid;
    logic [1:0]            o_status;
    logic [IDX_W-1:0]      o_moved_index;
    logic [COORD_BITS-1:0] o_out_x;
    logic [COORD_BITS-1:0] o_out_y;
    logic [COORD_BITS-1:0] o_out_z;
    logic [RAD_W-1:0]      o_out_radius;
    logic [31:0]           o_accepted_count;

    move_scoreboard sb;
    bit             loaded [MAX_SPHERES];  // store entries that may be read back
    bit             idle_on;               // random gaps before words in this phase
    bit             quiet_tail;            // last part of the run: no gaps at all
    int             random_words;
    int             spare_words;
    int             cycles;

    hard_sphere_metropolis_move i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_type       (i_req_type),
        .i_particle_index (i_particle_index),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_sphere_radius  (i_sphere_radius),
        .i_rand_x         (i_rand_x),
        .i_rand_y         (i_rand_y),
        .i_rand_z         (i_rand_z),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_moved_index    (o_moved_index),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_out_z          (o_out_z),
        .o_out_radius     (o_out_radius),
        .o_accepted_count (o_accepted_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sample at the edge itself: a result word is taken at the edge ending its strobe
    // cycle, and a request word at an edge with start high and busy low. Check before
    // noting, so a word finishing at the same edge meets the older expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_word({o_status, o_moved_index, o_out_x, o_out_y, o_out_z,
                               o_out_radius, o_accepted_count});
            if (start && !busy)
                sb.note_word({i_req_type, i_particle_index, i_pos_x, i_pos_y, i_pos_z,
                              i_sphere_radius, i_rand_x, i_rand_y, i_rand_z});
        end
    end

    // Hard stop if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("ERROR: run stopped at the cycle limit, %0d words still awaited",
                     sb.pending());
            $display("hard_sphere_metropolis_move test failed");
            $finish;
        end
    end

    // Present one request word and hold it until the block takes it. Returns at the
    // accepting edge with start still high, so a following word can go straight on.
    task automatic send_word(input logic [1:0] req, input int idx, input int px,
                             input int py, input int pz, input int rad, input int ux,
                             input int uy, input int uz);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_req_type       <= req;
        i_particle_index <= IDX_W'(idx);
        i_pos_x          <= COORD_BITS'(px);
        i_pos_y          <= COORD_BITS'(py);
        i_pos_z          <= COORD_BITS'(pz);
        i_sphere_radius  <= RAD_W'(rad);
        i_rand_x         <= COORD_BITS'(ux);
        i_rand_y         <= COORD_BITS'(uy);
        i_rand_z         <= COORD_BITS'(uz);
        start            <= 1'b1;
        if (req == REQ_LOAD) loaded[IDX_W'(idx)] = 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Unused fields of each request carry random bits so that every input bit toggles.
    task automatic load_sphere(input int idx, input int x, input int y, input int z,
                               input int r);
        send_word(REQ_LOAD, idx, x, y, z, r, $urandom, $urandom, $urandom);
    endtask

    task automatic read_sphere(input int idx);
        send_word(REQ_READ, idx, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
    endtask

    task automatic trial_move(input int ux, input int uy, input int uz);
        send_word(REQ_TRIAL, $urandom, $urandom, $urandom, $urandom, $urandom, ux, uy, uz);
    endtask

    // Change the count only with the block idle: drain, let any ignored word finish,
    // then write it for one cycle.
    task automatic write_count(input logic [CNT_W-1:0] value);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_count(value);
    endtask

    // Mostly plain uniform draws, with the ends and the midpoint now and then.
    function automatic int pick_fraction();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 65535;
            2:       return 32768;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Small radii keep spheres movable; the odd large one drives redraws.
    function automatic int pick_radius();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 32767);
        return $urandom_range(0, 3000);
    endfunction

    // Load every sphere in use. Large sets go on a jittered 16x8x8 grid so they start
    // apart; small sets are scattered, some packed against the previous sphere.
    task automatic fill_spheres(input int n);
        int px, py, pz;
        px = 32768;
        py = 32768;
        pz = 32768;
        for (int k = 0; k < n; k++) begin
            if (n > 64) begin
                px = (k % 16) * 4096 + 2048 + $urandom_range(0, 1000) - 500;
                py = ((k / 16) % 8) * 8192 + 4096 + $urandom_range(0, 1000) - 500;
                pz = (k / 128) * 8192 + 4096 + $urandom_range(0, 1000) - 500;
                load_sphere(k, px, py, pz, $urandom_range(0, 1500));
            end else begin
                if (k > 0 && $urandom_range(0, 5) == 0) begin
                    px = px + $urandom_range(0, 4000) - 2000;
                    py = py + $urandom_range(0, 4000) - 2000;
                    pz = pz + $urandom_range(0, 4000) - 2000;
                end else begin
                    px = $urandom_range(0, 65535);
                    py = $urandom_range(0, 65535);
                    pz = $urandom_range(0, 65535);
                end
                load_sphere(k, px, py, pz, pick_radius());
            end
        end
    endtask

    // One phase: set the count, load the spheres in use, then mostly trial moves with
    // reads, stray loads and ignored words mixed in.
    task automatic run_phase(input logic [CNT_W-1:0] count, input int n_items);
        int n;
        int pick;
        int idx;
        write_count(count);
        n       = sb.in_use();
        idle_on = !quiet_tail && $urandom_range(0, 3) != 0;
        fill_spheres(n);
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                trial_move(pick_fraction(), pick_fraction(), pick_fraction());
            end else if (pick < 88) begin
                idx = $urandom_range(0, MAX_SPHERES - 1);
                if (!loaded[idx]) idx = $urandom_range(0, n - 1);
                read_sphere(idx);
            end else if (pick < 94) begin
                load_sphere($urandom_range(0, MAX_SPHERES - 1), $urandom, $urandom, $urandom,
                            pick_radius());
            end else begin
                send_word(REQ_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
                spare_words++;
            end
            if (pick < 94) random_words++;
        end
    endtask

    initial begin
        sb           = new();
        cycles       = 0;
        random_words = 0;
        spare_words  = 0;
        quiet_tail   = 1'b0;
        idle_on      = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: three spheres, field extremes, each outcome of a trial.
        write_count(3);
        load_sphere(0, 65535, 65535, 65535, 32767);
        read_sphere(0);
        load_sphere(0, 0, 0, 0, 0);
        read_sphere(0);
        load_sphere(0, 32768, 32768, 32768, 1000);
        load_sphere(1, 34768, 32768, 32768, 1000);      // touching sphere 0
        load_sphere(2, 4000, 32768, 32768, 2000);
        load_sphere(1023, 1, 2, 3, 4);                  // top of the store, outside the box
        trial_move(32768, 32768, 32768);                // no displacement, contact only
        trial_move(0, 32768, 32768);                    // pushed into sphere 0
        trial_move(0, 32768, 32768);                    // lands exactly on the wall
        trial_move(65535, 65535, 32768);
        trial_move(65535, 0, 65535);                    // turn wraps back to sphere 0
        read_sphere(1023);
        read_sphere(2);
        send_word(REQ_SPARE, 5, 6, 7, 8, 9, 10, 11, 12);
        spare_words++;
        load_sphere(1, 34768, 32768, 32768, 1000);      // clears both counters
        trial_move(0, 0, 0);
        trial_move(65535, 65535, 65535);

        // Random part: a lone sphere, a zero count, small sets of random size, then large sets.
        run_phase(1, 30);
        run_phase(0, 20);
        run_phase(2, 30);
        while (random_words < RANDOM_WORDS - 170)
            run_phase(CNT_W'($urandom_range(3, 24)), $urandom_range(20, 45));
        run_phase(CNT_W'($urandom_range(65, 200)), 30);
        run_phase(CNT_W'(MAX_SPHERES), 30);
        run_phase(CNT_W'(2047), 10);                     // clamps to the full store

        // Last stretch back to back, no gaps.
        quiet_tail = 1'b1;
        do run_phase(CNT_W'($urandom_range(2, 16)), 40);
        while (random_words < RANDOM_WORDS);

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d result words: %0d load/read, %0d accepted, %0d overlap, %0d redraw",
                 sb.words_checked, sb.status_seen[ST_DONE], sb.status_seen[ST_ACCEPT],
                 sb.status_seen[ST_REJECT], sb.status_seen[ST_REDRAW]);
        $display("Counts 0 to 2047 exercised, %0d ignored requests, %0d mismatches",
                 spare_words, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("hard_sphere_metropolis_move test passed");
        end else begin
            $display("hard_sphere_metropolis_move test failed");
        end
        $finish;
    end
endmodule
